### hdl/ping_pong_smoothstep_sweep_core_macros.svh
// Assertion helpers shared by the sweep core.
`ifndef PING_PONG_SMOOTHSTEP_SWEEP_CORE_MACROS_SVH
`define PING_PONG_SMOOTHSTEP_SWEEP_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PPSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PPSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ppss_pkg.sv
package ppss_pkg;

  // Field widths of the item and configuration ports.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned AMP_W      = 24;
  localparam int unsigned STROKE_W   = 24;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned VEL_W      = 26;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 1;

  // Default phase resolution in fractional bits.
  localparam int unsigned PHASE_FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE    = 1'b0,
    REG_STROKE_TICKS = 1'b1
  } cfg_reg_t;

endpackage

### hdl/ping_pong_smoothstep_sweep_core.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+--------------------------------
// input    | in_valid / in_stall          | time_ticks (s32)
// output   | out_valid / out_stall        | position (s24), velocity (s26)
// config   | cfg_write_en                 | cfg_index (1), cfg_data (24)
//
// One item enters per clock while no held result stalls the pipeline.
// Two bit-serial restoring dividers make up most of the pipeline, one quotient bit per stage:
// PHASE_FRAC_BITS + 31 stages for stroke and phase, 25 stages for velocity.
// Reset clears only the valid bits and the two configuration registers.
// A stalled result freezes the whole pipeline; in_stall follows it in the same cycle.
module ping_pong_smoothstep_sweep_core import ppss_pkg::*; #(
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [TIME_W-1:0]     time_ticks,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [POS_W-1:0]      position,
  output logic signed [VEL_W-1:0]      velocity,
  input  logic                         cfg_write_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

`include "ping_pong_smoothstep_sweep_core_macros.svh"

  localparam int unsigned P     = PHASE_FRAC_BITS;
  localparam int unsigned CT_W  = TIME_W - 1;          // clamped time is nonnegative
  localparam int unsigned DIVW  = CT_W + P;            // dividend of the phase divider
  localparam int unsigned MAG_W = VEL_W - 1;           // velocity magnitude before sign
  localparam int unsigned PW    = P + 4;               // polynomial width
  localparam int unsigned SW    = AMP_W + P + 3;       // scaled product width
  localparam int unsigned LAT   = DIVW + MAG_W + 8;    // valid-chain length
  localparam int unsigned IDX_C = DIVW + 3;            // stage holding S(r)

  localparam logic [P:0]    ONE       = {1'b1, {P{1'b0}}};
  localparam logic [PW-1:0] POLY_BASE = PW'(10) << P;
  localparam logic signed [AMP_W+2:0] POS_HI = (AMP_W+3)'(2**(POS_W-1) - 1);
  localparam logic signed [AMP_W+2:0] POS_LO = -POS_HI - (AMP_W+3)'(1);

  // Configuration registers.
  logic signed [AMP_W-1:0]    amplitude;
  logic        [STROKE_W-1:0] stroke_ticks;

  // Pipeline control.
  logic           adv;
  logic           in_fire;
  logic [LAT-1:0] stage_valid;

  // Phase divider stages; index 0 is the input register.
  logic [STROKE_W-1:0] d1_rem  [DIVW+1];
  logic [DIVW-1:0]     d1_work [DIVW+1];

  // Polynomial stages.
  logic [P-1:0]  a_r, a_r2, a_q;
  logic          a_kz, a_ko;
  logic [P-1:0]  b_r3, b_qq;
  logic [PW-1:0] b_poly;
  logic          b_kz, b_ko;
  logic [P:0]    c_s, c_ds;
  logic          c_kz, c_ko;
  logic signed [AMP_W+P+1:0] d_as, d_ads;
  logic          d_kz, d_ko;
  logic signed [SW-1:0]  e_ps, e_vs;
  logic signed [AMP_W:0] e_a0;

  // Velocity divider stages; index 0 holds the finished position and the signed numerator.
  logic [STROKE_W-1:0]    d2_rem  [MAG_W+1];
  logic [MAG_W-1:0]       d2_work [MAG_W+1];
  logic                   d2_neg  [MAG_W+1];
  logic signed [POS_W-1:0] d2_pos [MAG_W+1];

  // Combinational helpers.
  logic [P-1:0]     q_r;
  logic [P:0]       one_minus_r;
  logic [2*P-1:0]   mul_rr;
  logic [2*P:0]     mul_rq;
  logic [2*P-1:0]   mul_r3;
  logic [2*P-1:0]   mul_qq;
  logic [PW-1:0]    poly_next;
  logic [2*P+3:0]   mul_s;
  logic [P+3:0]     s_floor;
  logic [P+4:0]     ds_full;
  logic signed [AMP_W+P+1:0] as_prod, ads_prod;
  logic signed [SW-1:0]      ps_ext, vs_ext;
  logic signed [SW-1:0]      ps_sh, vs_sh;
  logic signed [AMP_W+2:0]   pos_sum;
  logic signed [POS_W-1:0]   pos_clip;
  logic [VEL_W-1:0]          vel_num;
  logic [MAG_W-1:0]          vel_q;

  // One restoring-division step: does the shifted remainder reach the divisor?
  function automatic logic div_ge(input logic [STROKE_W-1:0] rem, input logic din,
                                  input logic [STROKE_W-1:0] den);
    logic [STROKE_W:0] trial;
    trial = {rem, din};
    return trial >= {1'b0, den};
  endfunction

  // One restoring-division step: the remainder left for the next stage.
  function automatic logic [STROKE_W-1:0] div_rem(input logic [STROKE_W-1:0] rem,
                                                  input logic din,
                                                  input logic [STROKE_W-1:0] den);
    logic [STROKE_W:0] trial;
    logic [STROKE_W:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return diff[STROKE_W-1:0];
    end
    return trial[STROKE_W-1:0];
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= '0;
      stroke_ticks <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMPLITUDE:    amplitude    <= $signed(cfg_data[AMP_W-1:0]);
        REG_STROKE_TICKS: stroke_ticks <= cfg_data[STROKE_W-1:0];
      endcase
    end
  end

  // The whole pipeline moves unless a finished result is held back.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_fire  = in_valid && adv;
  assign out_valid = stage_valid[LAT-1];

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[LAT-2:0], in_fire};
    end
  end

  // Input register with negative time clamped to zero; then the phase divider.
  // The quotient of (t << P) / T holds the stroke index above the phase bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_rem[0]  <= '0;
      d1_work[0] <= time_ticks[TIME_W-1] ? '0 : {time_ticks[CT_W-1:0], {P{1'b0}}};
      for (int i = 0; i < DIVW; i++) begin
        d1_rem[i+1]  <= div_rem(d1_rem[i], d1_work[i][DIVW-1], stroke_ticks);
        d1_work[i+1] <= {d1_work[i][DIVW-2:0],
                         div_ge(d1_rem[i], d1_work[i][DIVW-1], stroke_ticks)};
      end
    end
  end

  // Stage A: r^2 and r*(1-r).
  assign q_r         = d1_work[DIVW][P-1:0];
  assign one_minus_r = ONE - {1'b0, q_r};
  assign mul_rr      = q_r * q_r;
  assign mul_rq      = q_r * one_minus_r;

  // Stage B: r^3, the quintic's inner polynomial and q^2.
  assign mul_r3    = a_r2 * a_r;
  assign mul_qq    = a_q * a_q;
  assign poly_next = POLY_BASE + PW'(a_r2) * PW'(6) - PW'(a_r) * PW'(15);

  // Stage C: S(r) clamped to one, and the derivative 30*q^2.
  assign mul_s   = b_r3 * b_poly;
  assign s_floor = mul_s[2*P+3:P];
  assign ds_full = (P+5)'(b_qq) * (P+5)'(30);

  // Stage D: scale by amplitude.
  assign as_prod  = amplitude * $signed({1'b0, c_s});
  assign ads_prod = amplitude * $signed({1'b0, c_ds});

  // Stage E operands.
  assign ps_ext = SW'(d_as);
  assign vs_ext = SW'(d_ads);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r  <= q_r;
      a_r2 <= mul_rr[2*P-1:P];
      a_q  <= mul_rq[2*P-1:P];
      a_kz <= ~|d1_work[DIVW][DIVW-1:P];
      a_ko <= d1_work[DIVW][P];

      b_r3   <= mul_r3[2*P-1:P];
      b_qq   <= mul_qq[2*P-1:P];
      b_poly <= poly_next;
      b_kz   <= a_kz;
      b_ko   <= a_ko;

      c_s  <= (s_floor > {3'b000, ONE}) ? ONE : s_floor[P:0];
      c_ds <= ds_full[P:0];
      c_kz <= b_kz;
      c_ko <= b_ko;

      d_as  <= as_prod;
      d_ads <= ads_prod;
      d_kz  <= c_kz;
      d_ko  <= c_ko;

      // Stroke zero rises from 0 by +A; odd strokes fall from +A; even ones rise from -A.
      if (d_kz) begin
        e_ps <= ps_ext;
        e_vs <= vs_ext;
        e_a0 <= '0;
      end else if (d_ko) begin
        e_ps <= -(ps_ext <<< 1);
        e_vs <= -(vs_ext <<< 1);
        e_a0 <= (AMP_W+1)'(amplitude);
      end else begin
        e_ps <= ps_ext <<< 1;
        e_vs <= vs_ext <<< 1;
        e_a0 <= -((AMP_W+1)'(amplitude));
      end
    end
  end

  // Stage F: position with saturation; velocity numerator split into sign and magnitude.
  // The numerator floor(A*d*dS / 2^P) always fits VEL_W signed bits, so the floor quotient
  // never needs saturation.
  assign ps_sh   = e_ps >>> P;
  assign vs_sh   = e_vs >>> P;
  assign pos_sum = $signed(ps_sh[AMP_W+2:0]) + (AMP_W+3)'(e_a0);
  assign vel_num = vs_sh[VEL_W-1:0];

  always_comb begin
    if (pos_sum > POS_HI) begin
      pos_clip = POS_HI[POS_W-1:0];
    end else if (pos_sum < POS_LO) begin
      pos_clip = POS_LO[POS_W-1:0];
    end else begin
      pos_clip = pos_sum[POS_W-1:0];
    end
  end

  // Velocity divider: floor division works on ~n for negative n and inverts the quotient.
  always_ff @(posedge clk) begin
    if (adv) begin
      d2_rem[0]  <= '0;
      d2_work[0] <= vel_num[VEL_W-1] ? ~vel_num[MAG_W-1:0] : vel_num[MAG_W-1:0];
      d2_neg[0]  <= vel_num[VEL_W-1];
      d2_pos[0]  <= pos_clip;
      for (int j = 0; j < MAG_W; j++) begin
        d2_rem[j+1]  <= div_rem(d2_rem[j], d2_work[j][MAG_W-1], stroke_ticks);
        d2_work[j+1] <= {d2_work[j][MAG_W-2:0],
                         div_ge(d2_rem[j], d2_work[j][MAG_W-1], stroke_ticks)};
        d2_neg[j+1]  <= d2_neg[j];
        d2_pos[j+1]  <= d2_pos[j];
      end
    end
  end

  // Output register; a zero stroke length forces both fields to zero.
  assign vel_q = d2_work[MAG_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (stroke_ticks == '0) begin
        position <= '0;
        velocity <= '0;
      end else begin
        position <= d2_pos[MAG_W];
        velocity <= d2_neg[MAG_W] ? $signed(~{1'b0, vel_q}) : $signed({1'b0, vel_q});
      end
    end
  end

  // A phase of zero gives a zero derivative term in the stage A register.
  `PPSS_ASSERT_NEXT(a_zero_phase_q, clk, rst, stage_valid[DIVW] && adv && (q_r == '0), a_q == '0, "phase zero did not give q zero")

  // The smoothstep value never exceeds one.
  `PPSS_ASSERT_NOW(a_s_clamped, clk, rst, stage_valid[IDX_C], c_s <= ONE, "smoothstep above one")

  // A held result freezes every valid bit.
  `PPSS_ASSERT_NEXT(a_freeze, clk, rst, !adv, $stable(stage_valid), "pipeline moved during a stall")

endmodule
